[rtl/kss_pkg.sv]
// ----------------------------------------------------------------------------
// kss_pkg: shared types and constants for the knot span search block
// Word layouts, register indexes and the link carried along the knot cells.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int VALUE_BITS    = 32;   // signed Q16.16 knot / parameter
    localparam int SLOT_BITS     = 5;
    localparam int SPAN_BITS     = 5;
    localparam int TOL_BITS      = 16;
    localparam int COUNT_BITS    = 6;
    localparam int ORDER_BITS    = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam int MAX_KNOTS_DEF = 32;

    localparam int COUNT_MIN = 4;
    localparam int ORDER_MIN = 2;
    localparam int ORDER_MAX = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_RST = 6'd32;
    localparam logic [ORDER_BITS-1:0] ORDER_RST = 5'd4;
    localparam logic [TOL_BITS-1:0]   TOL_RST   = 16'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_KNOT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPLINE_ORDER = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SNAP_TOL     = 2'd2;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef logic signed [VALUE_BITS-1:0] t_val;

    typedef struct packed {
        t_op                  op;
        logic [SLOT_BITS-1:0] slot;
        t_val                 value;
    } t_in_word;

    typedef struct packed {
        logic [SPAN_BITS-1:0] span;
        logic                 outside;
    } t_out_word;

    // query token handed from cell to cell
    typedef struct packed {
        logic                 vld;
        t_val                 v;
        t_val                 prev;   // knot of the previous cell
        t_val                 klo;    // captured lower end knot
        t_val                 khi;    // captured upper end knot
        logic [SPAN_BITS-1:0] span;   // search result so far
    } t_link;

    typedef struct packed {
        logic is_lo;   // this cell holds the lower end knot
        logic is_hi;   // this cell holds the upper end knot
        logic pair;    // span (idx-1, idx) is inside the knot count
    } t_cell_sel;

    typedef struct packed {
        logic [TOL_BITS-1:0]  tol;
        logic [SPAN_BITS-1:0] lo_span;
        logic [SPAN_BITS-1:0] up_span;
    } t_fin_cfg;

    typedef struct packed {
        logic done;      // result moved to the output register
        logic pending;   // compare stage holds a query
    } t_fin_stat;

endpackage

[rtl/kss_cell.sv]
// ----------------------------------------------------------------------------
// kss_cell: one knot of the table
// Holds a knot, tests the span ending at it and passes the token on.
// ----------------------------------------------------------------------------
module kss_cell
    import kss_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wen,
    input  t_val      i_wdata,
    input  t_cell_sel i_sel,
    input  t_link     i_link,
    output t_link     o_link
);

    t_val  r_knot;
    t_link r_link;
    t_link n_link;
    logic  w_hit;

    always_comb begin
        w_hit  = i_sel.pair && (i_link.prev < i_link.v) && (i_link.v <= r_knot);
        n_link = i_link;
        n_link.prev = r_knot;
        if (w_hit) begin
            n_link.span = SPAN_BITS'(CELL_IDX - 1);
        end
        if (i_sel.is_lo) begin
            n_link.klo = r_knot;
        end
        if (i_sel.is_hi) begin
            n_link.khi = r_knot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_knot <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.vld <= 1'b0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;

endmodule

[rtl/kss_finish.sv]
// ----------------------------------------------------------------------------
// kss_finish: end-knot compare and result register
// Registers the range and snap compares, then picks span or outside.
// ----------------------------------------------------------------------------
module kss_finish
    import kss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_link     i_link,
    input  t_fin_cfg  i_cfg,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data,
    output t_fin_stat o_stat
);

    logic [VALUE_BITS:0] w_d_lo;
    logic [VALUE_BITS:0] w_d_hv;
    logic [VALUE_BITS:0] w_d_k;
    logic [VALUE_BITS:0] w_tol;

    logic                 r_f1_vld;
    logic                 r_lt_lo, r_snap_lo;
    logic                 r_gt_hi_v, r_snap_hi_v, r_eq_hi_v, r_eq_lo_v;
    logic                 r_gt_hi_k, r_snap_hi_k, r_eq_hi_k;
    logic [SPAN_BITS-1:0] r_span;

    logic                 w_take;
    logic                 w_outside;
    logic [SPAN_BITS-1:0] w_span;

    logic      r_out_vld;
    t_out_word r_out;

    // differences one bit wider than the value, read only where positive
    assign w_d_lo = {i_link.klo[VALUE_BITS-1], i_link.klo} - {i_link.v[VALUE_BITS-1], i_link.v};
    assign w_d_hv = {i_link.v[VALUE_BITS-1], i_link.v} - {i_link.khi[VALUE_BITS-1], i_link.khi};
    assign w_d_k  = {i_link.klo[VALUE_BITS-1], i_link.klo}
                  - {i_link.khi[VALUE_BITS-1], i_link.khi};
    assign w_tol  = (VALUE_BITS + 1)'(i_cfg.tol);

    always_ff @(posedge i_clk) begin
        if (i_link.vld) begin
            r_lt_lo     <= i_link.v < i_link.klo;
            r_snap_lo   <= w_d_lo < w_tol;
            r_gt_hi_v   <= i_link.v > i_link.khi;
            r_snap_hi_v <= w_d_hv < w_tol;
            r_eq_hi_v   <= i_link.v == i_link.khi;
            r_eq_lo_v   <= i_link.v == i_link.klo;
            r_gt_hi_k   <= i_link.klo > i_link.khi;
            r_snap_hi_k <= w_d_k < w_tol;
            r_eq_hi_k   <= i_link.klo == i_link.khi;
            r_span      <= i_link.span;
        end
    end

    // snapped below -> value becomes klo; upper end test comes first
    always_comb begin
        w_outside = 1'b0;
        w_span    = r_span;
        if (r_lt_lo) begin
            if (!r_snap_lo) begin
                w_outside = 1'b1;
            end else if (r_gt_hi_k) begin
                if (r_snap_hi_k) begin
                    w_span = i_cfg.up_span;
                end else begin
                    w_outside = 1'b1;
                end
            end else if (r_eq_hi_k) begin
                w_span = i_cfg.up_span;
            end else begin
                w_span = i_cfg.lo_span;
            end
        end else if (r_gt_hi_v) begin
            if (r_snap_hi_v) begin
                w_span = i_cfg.up_span;
            end else begin
                w_outside = 1'b1;
            end
        end else if (r_eq_hi_v) begin
            w_span = i_cfg.up_span;
        end else if (r_eq_lo_v) begin
            w_span = i_cfg.lo_span;
        end
        if (w_outside) begin
            w_span = '0;
        end
    end

    assign w_take = r_f1_vld && (!r_out_vld || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_link.vld) begin
                r_f1_vld <= 1'b1;
            end else if (w_take) begin
                r_f1_vld <= 1'b0;
            end
            if (w_take) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out.span    <= w_span;
            r_out.outside <= w_outside;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_data         = r_out;
    assign o_stat.done    = w_take;
    assign o_stat.pending = r_f1_vld;

endmodule

[rtl/knot_span_search_top.sv]
// ----------------------------------------------------------------------------
// knot_span_search_top: B-spline knot span search
// Knot table held in a row of cells; queries sweep the row for their span.
// ----------------------------------------------------------------------------
// A load word (op = load) writes one signed Q16.16 knot into the cell picked
// by slot; slots at or beyond MAX_KNOTS are dropped. A query word (op = query)
// enters cell 0 and moves one cell per cycle along the row of MAX_KNOTS knot
// cells, picking up the two end knots and the last span i with
// knot[i] < v <= knot[i+1]; a compare stage then applies the end rules and
// the snap tolerance, and the result lands in the output register. A query
// holds the input through the row sweep, the compare stage and the output
// register load, longer if the output is stalled; loads are taken one per
// cycle whenever no query is in flight, even while a result
// waits at the output. Knots must be loaded before a query reads them: knots
// 0 .. knot_count-1 are read, and an unloaded knot gives an arbitrary span.
// Config writes are always taken and must only happen while idle.
// ----------------------------------------------------------------------------
module knot_span_search_top
    import kss_pkg::*;
#(
    parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // item input
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_in_word                 i_data,
    // result output
    output logic                     o_valid,
    input  logic                     i_stall,
    output t_out_word                o_data,
    // register writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // count width wide enough for MAX_KNOTS and the register field, plus
    // one bit of headroom for count+1
    localparam int CNT_W = ($clog2(MAX_KNOTS + 1) > COUNT_BITS) ?
                           $clog2(MAX_KNOTS + 1) : COUNT_BITS;
    localparam int XW    = CNT_W + 1;

    // ---- configuration registers
    logic [COUNT_BITS-1:0] r_knot_count;
    logic [ORDER_BITS-1:0] r_spline_order;
    logic [TOL_BITS-1:0]   r_snap_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count   <= COUNT_RST;
            r_spline_order <= ORDER_RST;
            r_snap_tol     <= TOL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KNOT_COUNT:   r_knot_count   <= i_cfg_data[COUNT_BITS-1:0];
                CFG_SPLINE_ORDER: r_spline_order <= i_cfg_data[ORDER_BITS-1:0];
                CFG_SNAP_TOL:     r_snap_tol     <= i_cfg_data[TOL_BITS-1:0];
                default:          ;   // unmapped index, write dropped
            endcase
        end
    end

    // ---- derived indexes (static between config writes)
    logic [XW-1:0] w_kc, w_cnt, w_od, w_ord, w_lo, w_hi, w_up;

    always_comb begin
        w_kc = XW'(r_knot_count);
        if (w_kc < XW'(COUNT_MIN)) begin
            w_cnt = XW'(COUNT_MIN);
        end else if (w_kc > XW'(MAX_KNOTS)) begin
            w_cnt = XW'(MAX_KNOTS);
        end else begin
            w_cnt = w_kc;
        end

        w_od = XW'(r_spline_order);
        if (w_od < XW'(ORDER_MIN)) begin
            w_ord = XW'(ORDER_MIN);
        end else if (w_od > XW'(ORDER_MAX)) begin
            w_ord = XW'(ORDER_MAX);
        end else begin
            w_ord = w_od;
        end

        // lower end: order-1, capped at the last knot
        w_lo = ((w_ord - XW'(1)) < (w_cnt - XW'(1))) ? (w_ord - XW'(1)) : (w_cnt - XW'(1));
        // upper end: count-order+1, floored at 0 (never above count-1)
        w_hi = ((w_cnt + XW'(1)) > w_ord) ? (w_cnt + XW'(1) - w_ord) : '0;
        // span reported at the upper end knot
        w_up = (w_cnt > (w_ord + XW'(1))) ? (w_cnt - w_ord - XW'(1)) : '0;
    end

    // ---- input handshake
    logic w_in_acc, w_query_acc, w_load_acc;
    logic r_busy;   // a query is in the row or the compare stage

    assign o_stall     = r_busy;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_query_acc = w_in_acc && (i_data.op == OP_QUERY);
    assign w_load_acc  = w_in_acc && (i_data.op == OP_LOAD);

    // ---- knot cell row
    t_link     w_head;
    t_link     w_link [MAX_KNOTS+1];
    t_cell_sel w_sel  [MAX_KNOTS];
    logic      w_wen  [MAX_KNOTS];
    logic [MAX_KNOTS-1:0] w_tok_vld;

    always_comb begin
        w_head     = '0;
        w_head.vld = w_query_acc;
        w_head.v   = i_data.value;
    end

    assign w_link[0] = w_head;

    genvar g;
    generate
        for (g = 0; g < MAX_KNOTS; g++) begin : g_cell
            assign w_wen[g]       = w_load_acc && (32'(i_data.slot) == 32'(g));
            assign w_sel[g].is_lo = (w_lo == XW'(g));
            assign w_sel[g].is_hi = (w_hi == XW'(g));
            assign w_sel[g].pair  = (g != 0) && (XW'(g) < w_cnt);
            assign w_tok_vld[g]   = w_link[g+1].vld;

            kss_cell #(
                .CELL_IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wen   (w_wen[g]),
                .i_wdata (i_data.value),
                .i_sel   (w_sel[g]),
                .i_link  (w_link[g]),
                .o_link  (w_link[g+1])
            );
        end
    endgenerate

    // ---- compare stage and output register
    t_fin_cfg  w_fin_cfg;
    t_fin_stat w_stat;

    assign w_fin_cfg.tol     = r_snap_tol;
    assign w_fin_cfg.lo_span = w_lo[SPAN_BITS-1:0];
    assign w_fin_cfg.up_span = w_up[SPAN_BITS-1:0];

    kss_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (w_link[MAX_KNOTS]),
        .i_cfg   (w_fin_cfg),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_query_acc) begin
            r_busy <= 1'b1;
        end else if (w_stat.done) begin
            r_busy <= 1'b0;
        end
    end

    // ---- checks
    // only one query token exists between the input and the output register
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_tok_vld, w_stat.pending}) <= 1)
        else $error("more than one query in flight");

    // a token anywhere in the row means the input is held off
    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_tok_vld) |-> r_busy)
        else $error("query in row while input open");

    // a query locks the input on the following cycle
    a_query_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query_acc |=> (r_busy && w_tok_vld[0]))
        else $error("query did not enter the row");

    // an out-of-range result carries span zero
    a_outside_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.outside) |-> (o_data.span == '0))
        else $error("outside result with nonzero span");

endmodule

[tb/knot_span_search_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knot_span_search_top_tb: self-checking bench for the knot span search
// Loads knot rows, sweeps span queries across them and compares every result
// word with a span predictor kept in step with the loads and register writes.
// ----------------------------------------------------------------------------
// Flow: an initial block fills a job queue with words, register writes, drain
// points and long output holds. A clocked driver plays the queue into the
// block and updates the predictor as each word is taken. A clocked monitor
// stalls the result side at random and checks each result word against the
// oldest predicted span. A directed opening checks the end-knot rules, snap
// and no-snap at the tolerance edge, zero tolerance and extreme knot values.
// Random phases follow, each under its own register setting. Every phase
// loads a fresh, mostly sorted knot row and then mixes queries with knot
// tweaks, noise loads and row rebuilds.
// ----------------------------------------------------------------------------
module knot_span_search_top_tb;
    import kss_pkg::*;

    localparam int     MAX_KNOTS     = MAX_KNOTS_DEF;
    localparam int     ITEM_TARGET   = 1650;
    localparam int     PHASES        = 12;
    localparam int     HOLD_CYCLES   = 400;            // long output hold-off
    localparam int     SETTLE_CYCLES = MAX_KNOTS + 4;  // a load may still be in flight
    localparam longint VAL_MIN       = -64'sd2147483648;
    localparam longint VAL_MAX       = 64'sd2147483647;
    localparam time    LIMIT_NS      = 10_000_000;

    typedef enum logic [1:0] {
        ACT_WORD,   // send one input word
        ACT_CFG,    // one register write
        ACT_SYNC,   // pause until every span is back, then settle
        ACT_HOLD    // start the long output hold
    } t_act;

    typedef struct {
        t_act                     act;
        t_in_word                 word;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
    } t_job;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     o_stall;
    t_in_word                 i_data      = '0;
    logic                     o_valid;
    logic                     i_stall     = 1'b0;
    t_out_word                o_data;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    knot_span_search_top #(
        .MAX_KNOTS(MAX_KNOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_job      jobs_q[$];       // filled by the stimulus block, drained by the driver
    t_out_word spans_due[$];    // predicted result words, oldest first

    // predictor copy of the block: knot row and the three registers
    t_val                  knots_sh [MAX_KNOTS];
    logic [COUNT_BITS-1:0] count_sh = COUNT_RST;
    logic [ORDER_BITS-1:0] order_sh = ORDER_RST;
    logic [TOL_BITS-1:0]   tol_sh   = TOL_RST;

    // generator view: what the queued jobs will have loaded by then
    longint                gen_knot [MAX_KNOTS];
    logic [COUNT_BITS-1:0] gen_count = COUNT_RST;
    logic [ORDER_BITS-1:0] gen_order = ORDER_RST;
    longint                gen_tol   = 1;
    int                    gen_items = 0;

    int send_idle_pct = 21;
    int recv_idle_pct = 62;

    logic hold_kick   = 1'b0;  // one-cycle pulse from the driver
    int   hold_left   = 0;
    int   settle_left = 0;

    int queries_issued = 0;    // driver side
    int results_taken  = 0;    // monitor side, nonblocking so the driver reads it cleanly
    int loads_sent     = 0;
    int cfg_writes     = 0;
    int outside_seen   = 0;
    int fail_count     = 0;

    // ------------------------------------------------------------------------
    // Span predictor
    // ------------------------------------------------------------------------
    // Register values saturate into their legal ranges, then both end indexes
    // are clamped into the knot count; the generator uses the same mapping.
    function automatic void end_indexes(input logic [COUNT_BITS-1:0] cnt_reg,
                                        input logic [ORDER_BITS-1:0] ord_reg,
                                        output int cnt, output int ord,
                                        output int lo, output int hi);
        cnt = (cnt_reg < COUNT_MIN) ? COUNT_MIN : (cnt_reg > MAX_KNOTS) ? MAX_KNOTS : cnt_reg;
        ord = (ord_reg < ORDER_MIN) ? ORDER_MIN : (ord_reg > ORDER_MAX) ? ORDER_MAX : ord_reg;
        lo  = ord - 1;
        lo  = (lo > cnt - 1) ? cnt - 1 : lo;
        hi  = cnt - ord + 1;
        hi  = (hi < 0) ? 0 : (hi > cnt - 1) ? cnt - 1 : hi;
    endfunction

    function automatic t_out_word locate_span(t_val v);
        int        cnt, ord, lo, hi, sp;
        longint    x, klo, khi, tol;
        t_out_word res;
        end_indexes(count_sh, order_sh, cnt, ord, lo, hi);
        x   = v;
        klo = knots_sh[lo];
        khi = knots_sh[hi];
        tol = longint'(tol_sh);
        res = '0;
        // below the lower end: snap only when strictly closer than the tolerance
        if (x < klo) begin
            if (klo - x < tol) begin
                x = klo;
            end else begin
                res.outside = 1'b1;
                return res;
            end
        end
        if (x > khi) begin
            if (x - khi < tol) begin
                x = khi;
            end else begin
                res.outside = 1'b1;
                return res;
            end
        end
        // upper end knot wins over the lower one; its span may clip at zero
        if (x == khi) begin
            sp = cnt - ord - 1;
            if (sp < 0) sp = 0;
        end else if (x == klo) begin
            sp = lo;
        end else begin
            sp = 0;
            for (int i = 0; i < cnt - 1; i++) begin
                if (knots_sh[i] < x && x <= knots_sh[i + 1]) sp = i;
            end
        end
        res.span = SPAN_BITS'(sp);
        return res;
    endfunction

    // a word has been taken by the block
    function automatic void note_word(t_in_word w);
        if (w.op == OP_LOAD) begin
            if (w.slot < MAX_KNOTS) knots_sh[w.slot] = w.value;
            loads_sent++;
        end else begin
            spans_due.push_back(locate_span(w.value));
            queries_issued++;
        end
    endfunction

    function automatic void note_cfg(logic [CFG_IDX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_KNOT_COUNT:   count_sh = data[COUNT_BITS-1:0];
            CFG_SPLINE_ORDER: order_sh = data[ORDER_BITS-1:0];
            CFG_SNAP_TOL:     tol_sh   = data[TOL_BITS-1:0];
            default: ;
        endcase
        cfg_writes++;
    endfunction

    // ------------------------------------------------------------------------
    // Job builders
    // ------------------------------------------------------------------------
    function automatic longint sat32(longint v);
        return (v < VAL_MIN) ? VAL_MIN : (v > VAL_MAX) ? VAL_MAX : v;
    endfunction

    function automatic longint rand_between(longint a, longint b);
        longint unsigned r;
        longint          t;
        if (b < a) begin
            t = a;
            a = b;
            b = t;
        end
        r = {$urandom, $urandom};
        return a + longint'(r % longint'(b - a + 1));
    endfunction

    function automatic void queue_load(int slot, longint v);
        t_job j;
        j.act        = ACT_WORD;
        j.word.op    = OP_LOAD;
        j.word.slot  = SLOT_BITS'(slot);
        j.word.value = t_val'(sat32(v));
        j.idx        = '0;
        j.data       = '0;
        gen_knot[slot] = sat32(v);
        gen_items++;
        jobs_q.push_back(j);
    endfunction

    function automatic void queue_query(longint v);
        t_job j;
        j.act        = ACT_WORD;
        j.word.op    = OP_QUERY;
        j.word.slot  = SLOT_BITS'($urandom);  // don't care on a query
        j.word.value = t_val'(sat32(v));
        j.idx        = '0;
        j.data       = '0;
        gen_items++;
        jobs_q.push_back(j);
    endfunction

    function automatic void queue_cfg(logic [CFG_IDX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] data);
        t_job j;
        j.act  = ACT_CFG;
        j.word = '0;
        j.idx  = idx;
        j.data = data;
        case (idx)
            CFG_KNOT_COUNT:   gen_count = data[COUNT_BITS-1:0];
            CFG_SPLINE_ORDER: gen_order = data[ORDER_BITS-1:0];
            CFG_SNAP_TOL:     gen_tol   = longint'(data[TOL_BITS-1:0]);
            default: ;
        endcase
        jobs_q.push_back(j);
    endfunction

    function automatic void queue_mark(t_act act);
        t_job j;
        j.act  = act;
        j.word = '0;
        j.idx  = '0;
        j.data = '0;
        jobs_q.push_back(j);
    endfunction

    // Load a fresh nondecreasing row into slots 0..cnt-1. Styles: from the
    // bottom of the range with big steps, around zero, tiny steps with many
    // repeats, and mid-size steps. Clamped rows repeat the end knots.
    function automatic int build_row(int cnt, int ord);
        longint row [MAX_KNOTS];
        longint k, step_max;
        bit     clamped, flat;
        case ($urandom_range(3))
            0: begin
                k        = VAL_MIN + $urandom_range(255);
                step_max = 64'd134217728;
            end
            1: begin
                k        = longint'(int'($urandom)) >>> 8;
                step_max = 64'h20000;
            end
            2: begin
                k        = longint'(int'($urandom));
                step_max = 4;
            end
            default: begin
                k        = longint'(int'($urandom)) >>> 4;
                step_max = 64'h100_0000;
            end
        endcase
        clamped = $urandom_range(1);
        for (int i = 0; i < cnt; i++) begin
            row[i] = sat32(k);
            flat   = clamped && (i < ord - 1 || i >= cnt - ord);
            if (!flat && $urandom_range(4) != 0) k += rand_between(1, step_max);
        end
        if ($urandom_range(1)) begin
            for (int i = 0; i < cnt; i++) queue_load(i, row[i]);
        end else begin
            for (int i = cnt - 1; i >= 0; i--) queue_load(i, row[i]);
        end
        return cnt;
    endfunction

    // Query values cluster on knots, on the tolerance edges at both ends and
    // inside spans; a few are fully random, at the extremes of the range, zero or -1.
    function automatic longint pick_query(int cnt, int lo, int hi);
        int     i, sel;
        longint a, b;
        i   = $urandom_range(cnt - 1);
        sel = $urandom_range(99);
        a   = gen_knot[i];
        b   = gen_knot[(i < cnt - 1) ? i + 1 : i];
        if (sel < 25) return a;
        if (sel < 40) return a + rand_between(-3, 3);
        if (sel < 52) return gen_knot[lo] - gen_tol + rand_between(-2, 2);
        if (sel < 64) return gen_knot[hi] + gen_tol + rand_between(-2, 2);
        if (sel < 66) return gen_knot[lo];
        if (sel < 68) return gen_knot[hi];
        if (sel < 85) return rand_between(a, b);
        if (sel < 93) return longint'(int'($urandom));
        case ($urandom_range(3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // One random phase: drain, write all three registers, load a row, then mix.
    function automatic void queue_phase(logic [CFG_DATA_BITS-1:0] cnt_d,
                                        logic [CFG_DATA_BITS-1:0] ord_d,
                                        logic [CFG_DATA_BITS-1:0] tol_d,
                                        int budget, bit long_hold);
        int     cnt, ord, lo, hi, made, pick, i;
        longint a, b;
        queue_mark(ACT_SYNC);
        queue_cfg(CFG_KNOT_COUNT, cnt_d);
        queue_cfg(CFG_SPLINE_ORDER, ord_d);
        queue_cfg(CFG_SNAP_TOL, tol_d);
        end_indexes(gen_count, gen_order, cnt, ord, lo, hi);
        made = build_row(cnt, ord);
        if (long_hold) queue_mark(ACT_HOLD);
        while (made < budget) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                queue_query(pick_query(cnt, lo, hi));
                made++;
            end else if (pick < 88) begin
                // move one knot while keeping it between its neighbors
                i = $urandom_range(cnt - 1);
                a = (i > 0) ? gen_knot[i - 1] : gen_knot[i] - 64'h10000;
                b = (i < cnt - 1) ? gen_knot[i + 1] : gen_knot[i] + 64'h10000;
                queue_load(i, rand_between(a, b));
                made++;
            end else if (pick < 96) begin
                // noise: any slot, any value; may leave the row unsorted
                queue_load($urandom_range(MAX_KNOTS - 1), longint'(int'($urandom)));
                made++;
            end else begin
                made += build_row(cnt, ord);
            end
        end
    endfunction

    // Wait until every job is played, every word taken and every span back.
    task automatic drain_all();
        do @(negedge i_clk);
        while (jobs_q.size() != 0 || i_valid || i_cfg_valid ||
               results_taken != queries_issued);
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver: plays the job queue; one nonblocking write per signal per edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        logic                     valid_nx, cfg_valid_nx, kick_nx;
        t_in_word                 data_nx;
        logic [CFG_IDX_BITS-1:0]  idx_nx;
        logic [CFG_DATA_BITS-1:0] cdata_nx;
        t_job                     job;
        valid_nx     = i_valid;
        data_nx      = i_data;
        cfg_valid_nx = i_cfg_valid;
        idx_nx       = i_cfg_index;
        cdata_nx     = i_cfg_data;
        kick_nx      = 1'b0;
        if (!i_rst_n) begin
            valid_nx     = 1'b0;
            cfg_valid_nx = 1'b0;
        end else begin
            // retire handshakes first so the next word can follow at once
            if (i_valid && !o_stall) begin
                note_word(i_data);
                valid_nx = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                note_cfg(i_cfg_index, i_cfg_data);
                cfg_valid_nx = 1'b0;
            end
            if (!valid_nx && !cfg_valid_nx) begin
                if (settle_left != 0) begin
                    settle_left--;
                end else if (jobs_q.size() != 0) begin
                    job = jobs_q[0];
                    case (job.act)
                        ACT_WORD: begin
                            // sender gaps only ever fall between words
                            if ($urandom_range(99) >= send_idle_pct) begin
                                valid_nx = 1'b1;
                                data_nx  = job.word;
                                void'(jobs_q.pop_front());
                            end
                        end
                        ACT_CFG: begin
                            cfg_valid_nx = 1'b1;
                            idx_nx       = job.idx;
                            cdata_nx     = job.data;
                            void'(jobs_q.pop_front());
                        end
                        ACT_SYNC: begin
                            if (results_taken == queries_issued) begin
                                settle_left = SETTLE_CYCLES;
                                void'(jobs_q.pop_front());
                            end
                        end
                        default: begin
                            kick_nx = 1'b1;
                            void'(jobs_q.pop_front());
                        end
                    endcase
                end
            end
        end
        i_valid     <= valid_nx;
        i_data      <= data_nx;
        i_cfg_valid <= cfg_valid_nx;
        i_cfg_index <= idx_nx;
        i_cfg_data  <= cdata_nx;
        hold_kick   <= kick_nx;
    end

    // long output hold, counted here; the sender keeps offering words meanwhile
    always @(posedge i_clk) begin
        if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random result stalls and field-by-field span checks
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (spans_due.size() == 0) begin
                    $display("%0t: result word with no query pending: span=%0d outside=%0b",
                             $time, o_data.span, o_data.outside);
                    fail_count++;
                end else begin
                    want = spans_due.pop_front();
                    if (o_data.span !== want.span) begin
                        $display("%0t: span mismatch: expected %0d, got %0d",
                                 $time, want.span, o_data.span);
                        fail_count++;
                    end
                    if (o_data.outside !== want.outside) begin
                        $display("%0t: outside mismatch: expected %0b, got %0b",
                                 $time, want.outside, o_data.outside);
                        fail_count++;
                    end
                    if (want.outside) outside_seen++;
                    results_taken <= results_taken + 1;
                end
            end
            i_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [CFG_DATA_BITS-1:0] cnt_set [PHASES];
        logic [CFG_DATA_BITS-1:0] ord_set [PHASES];
        logic [CFG_DATA_BITS-1:0] tol_set [PHASES];
        int                       budget;

        // register settings per phase: legal extremes, values that saturate,
        // data with upper bits set, then random ones
        cnt_set = '{16'd32, 16'd32, 16'd4, 16'd4, 16'd63, 16'd3,
                    16'd20, 16'd33, 16'd0, 16'hFFD0, 16'd0, 16'd0};
        ord_set = '{16'd4, 16'd16, 16'd16, 16'd2, 16'd0, 16'd31,
                    16'd5, 16'd1, 16'd17, 16'hFFE8, 16'd0, 16'd0};
        tol_set = '{16'd1, 16'hFFFF, 16'd300, 16'd0, 16'd0, 16'h0100,
                    16'd0, 16'd40, 16'd1, 16'h4000, 16'd0, 16'd0};
        tol_set[4]  = CFG_DATA_BITS'($urandom);
        tol_set[6]  = CFG_DATA_BITS'($urandom_range(2000));
        cnt_set[10] = CFG_DATA_BITS'($urandom_range(MAX_KNOTS, COUNT_MIN));
        ord_set[10] = CFG_DATA_BITS'($urandom_range(ORDER_MAX, ORDER_MIN));
        tol_set[10] = CFG_DATA_BITS'($urandom);
        cnt_set[11] = CFG_DATA_BITS'($urandom);
        ord_set[11] = CFG_DATA_BITS'($urandom);
        tol_set[11] = CFG_DATA_BITS'($urandom);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: four knots, order 2, so the ends are knot 1 and knot 3.
        // The reset count would read all 32 unloaded knots, so shrink first.
        queue_cfg(CFG_KNOT_COUNT, 16'd4);
        queue_cfg(CFG_SPLINE_ORDER, 16'd2);
        queue_cfg(CFG_SNAP_TOL, 16'h0100);
        queue_load(0, -100);
        queue_load(1, 0);
        queue_load(2, 64'h10000);
        queue_load(3, 64'h20000);
        queue_query(0);              // lower end knot
        queue_query(64'h20000);      // upper end knot
        queue_query(-1);             // snaps up
        queue_query(-255);           // just inside the tolerance
        queue_query(-256);           // at the tolerance: out of range
        queue_query(64'h200FF);      // snaps down
        queue_query(64'h20100);      // out of range above
        queue_query(64'h8000);       // interior of the first span
        queue_query(64'h10001);      // interior of the next span
        queue_query(VAL_MIN);
        queue_query(VAL_MAX);
        // zero tolerance: nothing snaps
        queue_mark(ACT_SYNC);
        queue_cfg(CFG_SNAP_TOL, 16'd0);
        queue_query(-1);
        queue_query(64'h20001);
        queue_query(64'h18000);
        // extreme knot values at both ends
        queue_load(0, VAL_MIN);
        queue_load(1, VAL_MIN);
        queue_load(2, VAL_MAX);
        queue_load(3, VAL_MAX);
        queue_query(VAL_MIN);
        queue_query(VAL_MAX);
        queue_query(0);

        budget = (ITEM_TARGET - gen_items) / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            // idle regimes: sender light / receiver heavy, swapped, then none
            if (p == 4 || p == 8) begin
                drain_all();
                send_idle_pct = (p == 4) ? 62 : 0;
                recv_idle_pct = (p == 4) ? 21 : 0;
            end
            queue_phase(cnt_set[p], ord_set[p], tol_set[p], budget, p == 1 || p == 9);
        end

        drain_all();
        repeat (MAX_KNOTS + 8) @(posedge i_clk);

        $display("Run covered %0d span queries (%0d out of range), %0d knot loads,",
                 queries_issued, outside_seen, loads_sent);
        $display("%0d register writes over %0d settings, stalls on both sides, long output holds.",
                 cfg_writes, PHASES + 2);
        if (fail_count == 0 && spans_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d failures, %0d spans still expected", fail_count, spans_due.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("%0t: timeout with %0d spans still expected", $time, spans_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
